FILE: rtl/core/lnwp_pkg.sv
`timescale 1ns / 1ps

package lnwp_pkg;

	// Field widths of the item and result ports.
	localparam int unsigned OP_W      = 2;
	localparam int unsigned PIXEL_W   = 12;
	localparam int unsigned NINE_W    = 9;
	localparam int unsigned PACK_W    = 32;
	localparam int unsigned BITS_W    = 6;
	localparam int unsigned LINE_W    = 12;

	// A pixel pair expands into three nine-bit words.
	localparam int unsigned CHUNK_W   = 3 * NINE_W;

	localparam logic [LINE_W-1:0] LINE_COUNT_MAX = '1;
	localparam logic              DATA_FLAG      = 1'b1;

	// Default queue depths.
	localparam int unsigned MID_DEPTH_DEF = 2;
	localparam int unsigned OUT_DEPTH_DEF = 2;

	// Item operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PIXEL_PAIR = 2'd0,
		OP_RAW_WORD   = 2'd1,
		OP_FLUSH_LINE = 2'd2
	} op_t;

	// Classified work handed from the front to the back.
	typedef struct packed {
		logic               flush;
		logic               long_chunk;
		logic [CHUNK_W-1:0] chunk;
	} work_t;

	// One result item.
	typedef struct packed {
		logic [PACK_W-1:0] packed_word;
		logic [BITS_W-1:0] word_bits;
		logic              last;
		logic [LINE_W-1:0] line_bits;
	} res_t;

	// Byte swap into memory order.
	function automatic logic [PACK_W-1:0] swap_bytes(input logic [PACK_W-1:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

FILE: rtl/core/lnwp_fifo.sv
`timescale 1ns / 1ps

module lnwp_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// Only act on requests the queue can honour.
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	assign rd_data = slots_q[rd_ptr_q];

	// Storage is written only where an item arrives.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/lnwp_front.sv
`timescale 1ns / 1ps

module lnwp_front #(
	parameter int unsigned MID_DEPTH = lnwp_pkg::MID_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lnwp_pkg::OP_W-1:0]     operation,
	input  logic [lnwp_pkg::PIXEL_W-1:0]  pixel_first,
	input  logic [lnwp_pkg::PIXEL_W-1:0]  pixel_second,
	input  logic [lnwp_pkg::NINE_W-1:0]   raw_word,
	input  logic                          work_pop,
	output lnwp_pkg::work_t               work_item,
	output logic                          work_empty
);

	lnwp_pkg::work_t work_new;
	logic            work_keep;
	logic [$bits(lnwp_pkg::work_t)-1:0] work_rd;

	// Classify the item: a pixel pair becomes three data words in one chunk,
	// a raw word sits left-aligned, and an unused code is dropped here.
	always_comb begin
		work_new  = '0;
		work_keep = 1'b0;
		case (operation)
			lnwp_pkg::OP_PIXEL_PAIR: begin
				work_keep           = 1'b1;
				work_new.long_chunk = 1'b1;
				work_new.chunk      = {lnwp_pkg::DATA_FLAG, pixel_first[11:4],
					lnwp_pkg::DATA_FLAG, pixel_first[3:0], pixel_second[11:8],
					lnwp_pkg::DATA_FLAG, pixel_second[7:0]};
			end
			lnwp_pkg::OP_RAW_WORD: begin
				work_keep      = 1'b1;
				work_new.chunk = {raw_word,
					(lnwp_pkg::CHUNK_W - lnwp_pkg::NINE_W)'(0)};
			end
			lnwp_pkg::OP_FLUSH_LINE: begin
				work_keep      = 1'b1;
				work_new.flush = 1'b1;
			end
			default: begin
				work_keep = 1'b0;
			end
		endcase
	end

	// Queue between front and back so that each side stalls on its own.
	lnwp_fifo #(
		.WIDTH ($bits(lnwp_pkg::work_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push && work_keep),
		.wr_data (work_new),
		.full    (full),
		.rd_en   (work_pop),
		.rd_data (work_rd),
		.empty   (work_empty)
	);

	assign work_item = lnwp_pkg::work_t'(work_rd);

endmodule

FILE: rtl/core/lnwp_back.sv
`timescale 1ns / 1ps

module lnwp_back #(
	parameter int unsigned OUT_DEPTH = lnwp_pkg::OUT_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lnwp_pkg::work_t work_item,
	input  logic            work_empty,
	output logic            work_pop,
	input  logic            pop,
	output lnwp_pkg::res_t  result,
	output logic            empty
);

	localparam int unsigned WIDE_W = 2 * lnwp_pkg::PACK_W;
	localparam int unsigned FILL_W = $clog2(lnwp_pkg::PACK_W);

	logic [lnwp_pkg::PACK_W-1:0] pending_q;
	logic [FILL_W-1:0]           fill_q;
	logic [lnwp_pkg::LINE_W-1:0] count_q;

	logic [WIDE_W-1:0]           wide;
	logic [FILL_W:0]             chunk_len;
	logic [FILL_W:0]             fill_sum;
	logic                        crosses;
	logic [lnwp_pkg::LINE_W:0]   count_sum;
	logic [lnwp_pkg::LINE_W-1:0] count_next;
	logic                        out_full;
	logic                        res_push;
	lnwp_pkg::res_t              res_new;
	logic [$bits(lnwp_pkg::res_t)-1:0] res_rd;

	// Take work whenever the result queue has room for a possible result.
	assign work_pop = !work_empty && !out_full;

	// Drop the chunk in after the bits already used and see whether it
	// crosses the word boundary.
	assign wide      = {pending_q, lnwp_pkg::PACK_W'(0)} |
		({work_item.chunk, (WIDE_W - lnwp_pkg::CHUNK_W)'(0)} >> fill_q);
	assign chunk_len = work_item.long_chunk ? (FILL_W + 1)'(lnwp_pkg::CHUNK_W)
		: (FILL_W + 1)'(lnwp_pkg::NINE_W);
	assign fill_sum  = {1'b0, fill_q} + chunk_len;
	assign crosses   = fill_sum[FILL_W];

	// Line bit count saturates at its maximum.
	assign count_sum  = {1'b0, count_q} + (lnwp_pkg::LINE_W + 1)'(chunk_len);
	assign count_next = count_sum[lnwp_pkg::LINE_W] ? lnwp_pkg::LINE_COUNT_MAX
		: count_sum[lnwp_pkg::LINE_W-1:0];

	// Form the result for a flush or a completed word.
	always_comb begin
		res_new = '0;
		if (work_item.flush) begin
			res_new.packed_word = lnwp_pkg::swap_bytes(pending_q);
			res_new.word_bits   = {1'b0, fill_q};
			res_new.last        = 1'b1;
			res_new.line_bits   = count_q;
		end else begin
			res_new.packed_word = lnwp_pkg::swap_bytes(wide[WIDE_W-1 -: lnwp_pkg::PACK_W]);
			res_new.word_bits   = lnwp_pkg::BITS_W'(lnwp_pkg::PACK_W);
		end
	end

	assign res_push = work_pop && (work_item.flush || crosses);

	// Packer state: a flush clears it, otherwise the leftover bits stay.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			fill_q    <= '0;
			count_q   <= '0;
		end else if (work_pop) begin
			if (work_item.flush) begin
				pending_q <= '0;
				fill_q    <= '0;
				count_q   <= '0;
			end else begin
				pending_q <= crosses ? wide[lnwp_pkg::PACK_W-1:0]
					: wide[WIDE_W-1 -: lnwp_pkg::PACK_W];
				fill_q    <= fill_sum[FILL_W-1:0];
				count_q   <= count_next;
			end
		end
	end

	// Result queue towards the consumer.
	lnwp_fifo #(
		.WIDTH ($bits(lnwp_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_new),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign result = lnwp_pkg::res_t'(res_rd);

endmodule

FILE: rtl/core/lcd_nine_bit_word_packer_unit.sv
`timescale 1ns / 1ps

// Packs nine-bit LCD words (raw words, or pixel pairs expanded to three data
// words) most significant bit first into 32-bit words, which come out
// byte-swapped; a flush item gives the partial word marked last with the line
// bit count. The block takes one item per clock cycle while full is low. An
// accepted item first waits in the queue behind the classifying front; the
// packing back end, whose combinational shift-and-merge of a chunk into the
// partial word sets the rate, takes it from there when the output queue has
// room and writes any result straight into the output queue. Results wait in
// an output queue of OUT_DEPTH entries; the front queue holds MID_DEPTH items,
// so a stalled consumer fills both before full rises.
module lcd_nine_bit_word_packer_unit #(
	parameter int unsigned MID_DEPTH = lnwp_pkg::MID_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = lnwp_pkg::OUT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [lnwp_pkg::OP_W-1:0]     operation,
	input  logic [lnwp_pkg::PIXEL_W-1:0]  pixel_first,
	input  logic [lnwp_pkg::PIXEL_W-1:0]  pixel_second,
	input  logic [lnwp_pkg::NINE_W-1:0]   raw_word,
	output logic                          empty,
	input  logic                          pop,
	output logic [lnwp_pkg::PACK_W-1:0]   packed_word,
	output logic [lnwp_pkg::BITS_W-1:0]   word_bits,
	output logic                          last,
	output logic [lnwp_pkg::LINE_W-1:0]   line_bits
);

	lnwp_pkg::work_t work_item;
	logic            work_empty;
	logic            work_pop;
	lnwp_pkg::res_t  result;

	// Front: accept and classify items.
	lnwp_front #(
		.MID_DEPTH (MID_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.raw_word     (raw_word),
		.work_pop     (work_pop),
		.work_item    (work_item),
		.work_empty   (work_empty)
	);

	// Back: pack the bits and queue the results.
	lnwp_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_item  (work_item),
		.work_empty (work_empty),
		.work_pop   (work_pop),
		.pop        (pop),
		.result     (result),
		.empty      (empty)
	);

	assign packed_word = result.packed_word;
	assign word_bits   = result.word_bits;
	assign last        = result.last;
	assign line_bits   = result.line_bits;

endmodule

FILE: rtl/core/lnwp_checker.sv
`timescale 1ns / 1ps

module lnwp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic [lnwp_pkg::PACK_W-1:0]   packed_word,
	input logic [lnwp_pkg::BITS_W-1:0]   word_bits,
	input logic                          last,
	input logic [lnwp_pkg::LINE_W-1:0]   line_bits
);

	// A word that is not last is always a full word with no line count.
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> (word_bits == lnwp_pkg::BITS_W'(lnwp_pkg::PACK_W)
			&& line_bits == '0))
		else $error("non-last item is not a full word");

	// A flushed partial word never holds a whole word.
	a_last_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> (word_bits < lnwp_pkg::BITS_W'(lnwp_pkg::PACK_W)))
		else $error("last item reports a full word");

	// An empty flushed word carries no bits.
	a_last_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last && word_bits == '0) |-> (packed_word == '0))
		else $error("empty flushed word carries bits");

	// A waiting item holds while it is not taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(packed_word) && $stable(word_bits)
			&& $stable(last) && $stable(line_bits)))
		else $error("waiting item changed");

endmodule

bind lcd_nine_bit_word_packer_unit lnwp_checker u_lnwp_checker (.*);

FILE: test/tb_lcd_nine_bit_word_packer_unit.sv
`timescale 1ns / 1ps

module tb_lcd_nine_bit_word_packer_unit;

	localparam int NINE = lnwp_pkg::NINE_W;
	localparam int PACK = lnwp_pkg::PACK_W;
	localparam int LINE_MAX = int'(lnwp_pkg::LINE_COUNT_MAX);
	localparam logic [lnwp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned DRAIN_CYCLES = 16;

	// One line item as the sender offers it.
	typedef struct packed {
		logic [lnwp_pkg::OP_W-1:0]    opcode;
		logic [lnwp_pkg::PIXEL_W-1:0] first_px;
		logic [lnwp_pkg::PIXEL_W-1:0] second_px;
		logic [lnwp_pkg::NINE_W-1:0]  raw;
	} line_item_t;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          push = 1'b0;
	logic                          full;
	logic [lnwp_pkg::OP_W-1:0]     operation = '0;
	logic [lnwp_pkg::PIXEL_W-1:0]  pixel_first = '0;
	logic [lnwp_pkg::PIXEL_W-1:0]  pixel_second = '0;
	logic [lnwp_pkg::NINE_W-1:0]   raw_word = '0;
	logic                          empty;
	logic                          pop = 1'b0;
	logic [lnwp_pkg::PACK_W-1:0]   packed_word;
	logic [lnwp_pkg::BITS_W-1:0]   word_bits;
	logic                          last;
	logic [lnwp_pkg::LINE_W-1:0]   line_bits;

	line_item_t      line_items[$];
	lnwp_pkg::res_t  expected_words[$];
	int unsigned     mismatches = 0;
	int unsigned     sender_idle_pct = 0;
	int unsigned     sink_stall_pct = 0;
	int unsigned     hold_left = 0;
	logic            hold_req = 1'b0;

	// Shadow of the packer state.
	logic [lnwp_pkg::PACK_W-1:0] pend_word = '0;
	int                          pend_fill = 0;
	int                          line_count = 0;
	logic                        word_done;
	logic [lnwp_pkg::PACK_W-1:0] done_word;

	lcd_nine_bit_word_packer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.pixel_first(pixel_first),
		.pixel_second(pixel_second),
		.raw_word(raw_word),
		.empty(empty),
		.pop(pop),
		.packed_word(packed_word),
		.word_bits(word_bits),
		.last(last),
		.line_bits(line_bits)
	);

	// Clock with a period of 8 ns.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Memory byte order of a packed word.
	function automatic logic [lnwp_pkg::PACK_W-1:0] to_memory_order(
			input logic [lnwp_pkg::PACK_W-1:0] v);
		logic [lnwp_pkg::PACK_W-1:0] r;
		for (int i = 0; i < 4; i++)
			r[8*i +: 8] = v[8*(3-i) +: 8];
		return r;
	endfunction

	// Appends one nine-bit word to the partial word, most significant bit first.
	task automatic shift_in_nine(input logic [lnwp_pkg::NINE_W-1:0] w);
		int avail;
		int spill;
		avail = PACK - pend_fill;
		if (avail >= NINE) begin
			pend_word = pend_word | ({23'd0, w} << (avail - NINE));
			pend_fill = pend_fill + NINE;
			if (pend_fill >= PACK) begin
				done_word = pend_word;
				word_done = 1'b1;
				pend_word = '0;
				pend_fill = 0;
			end
		end else begin
			spill = NINE - avail;
			done_word = pend_word | ({23'd0, w} >> spill);
			word_done = 1'b1;
			pend_word = {23'd0, w} << (PACK - spill);
			pend_fill = spill;
		end
		line_count = (line_count + NINE > LINE_MAX) ? LINE_MAX : line_count + NINE;
	endtask

	// Works out the word, if any, that an accepted item gives.
	task automatic pack_item(input line_item_t it);
		lnwp_pkg::res_t r;
		word_done = 1'b0;
		case (it.opcode)
			lnwp_pkg::OP_PIXEL_PAIR: begin
				shift_in_nine({lnwp_pkg::DATA_FLAG, it.first_px[11:4]});
				shift_in_nine({lnwp_pkg::DATA_FLAG, it.first_px[3:0],
					it.second_px[11:8]});
				shift_in_nine({lnwp_pkg::DATA_FLAG, it.second_px[7:0]});
			end
			lnwp_pkg::OP_RAW_WORD: begin
				shift_in_nine(it.raw);
			end
			lnwp_pkg::OP_FLUSH_LINE: begin
				r.packed_word = to_memory_order(pend_word);
				r.word_bits = lnwp_pkg::BITS_W'(pend_fill);
				r.last = 1'b1;
				r.line_bits = lnwp_pkg::LINE_W'(line_count);
				expected_words.push_back(r);
				pend_word = '0;
				pend_fill = 0;
				line_count = 0;
			end
			default: begin
			end
		endcase
		if (word_done) begin
			r.packed_word = to_memory_order(done_word);
			r.word_bits = lnwp_pkg::BITS_W'(PACK);
			r.last = 1'b0;
			r.line_bits = '0;
			expected_words.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_item(input logic [lnwp_pkg::OP_W-1:0] op,
			input logic [lnwp_pkg::PIXEL_W-1:0] a,
			input logic [lnwp_pkg::PIXEL_W-1:0] b,
			input logic [lnwp_pkg::NINE_W-1:0] w);
		line_item_t it;
		it.opcode = op;
		it.first_px = a;
		it.second_px = b;
		it.raw = w;
		line_items.push_back(it);
	endtask

	// Random pixel, leaning towards the extremes now and then.
	function automatic logic [lnwp_pkg::PIXEL_W-1:0] pick_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return lnwp_pkg::PIXEL_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic logic [lnwp_pkg::NINE_W-1:0] pick_raw();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return lnwp_pkg::NINE_W'($urandom_range(511));
		endcase
	endfunction

	// Random lines of pixel pairs and raw words, each normally closed by a flush.
	// Some lines are long enough for the line count to saturate.
	task automatic queue_random_lines(input int unsigned count);
		int unsigned made;
		int unsigned len;
		int unsigned roll;
		bit long_line;
		made = 0;
		while (made < count) begin
			long_line = ($urandom_range(11) == 0);
			len = long_line ? $urandom_range(260, 160) : $urandom_range(30);
			for (int k = 0; k < len; k++) begin
				roll = $urandom_range(99);
				if (roll < 4) begin
					queue_item(OP_UNUSED, pick_pixel(), pick_pixel(), pick_raw());
				end else if (roll < (long_line ? 90 : 55)) begin
					queue_item(lnwp_pkg::OP_PIXEL_PAIR, pick_pixel(), pick_pixel(),
						pick_raw());
					made++;
				end else begin
					queue_item(lnwp_pkg::OP_RAW_WORD, pick_pixel(), pick_pixel(),
						pick_raw());
					made++;
				end
			end
			if ($urandom_range(19) != 0) begin
				queue_item(lnwp_pkg::OP_FLUSH_LINE, pick_pixel(), pick_pixel(),
					pick_raw());
				made++;
			end
		end
	endtask

	task automatic wait_items_sent();
		while (line_items.size() != 0)
			@(negedge clk);
	endtask

	task automatic wait_words_back();
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count);
		@(posedge clk);
		sender_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		queue_random_lines(count);
		wait_items_sent();
	endtask

	// Sender: offers the oldest pending item unless it idles this cycle.
	always @(negedge clk) begin
		if (!arst_n || line_items.size() == 0 || $urandom_range(99) < sender_idle_pct) begin
			push <= 1'b0;
		end else begin
			push <= 1'b1;
			operation <= line_items[0].opcode;
			pixel_first <= line_items[0].first_px;
			pixel_second <= line_items[0].second_px;
			raw_word <= line_items[0].raw;
		end
	end

	// An item taken by the block updates the shadow state.
	always @(posedge clk) begin
		if (arst_n && push && !full)
			pack_item(line_items.pop_front());
	end

	// Long receiver hold-off, counted in cycles.
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_req)
			hold_left <= HOLD_CYCLES;
	end

	// Receiver: pops unless held off or stalling this cycle.
	always @(negedge clk) begin
		pop <= arst_n && hold_left == 0 && !($urandom_range(99) < sink_stall_pct);
	end

	// Compares each word taken from the block with the oldest expected one.
	always @(posedge clk) begin : word_check
		lnwp_pkg::res_t want;
		if (arst_n && pop && !empty) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %08h bits %0d last %0b",
					packed_word, word_bits, last));
			end else begin
				want = expected_words.pop_front();
				if (packed_word !== want.packed_word)
					report_mismatch($sformatf("packed_word %08h, expected %08h",
						packed_word, want.packed_word));
				if (word_bits !== want.word_bits)
					report_mismatch($sformatf("word_bits %0d, expected %0d",
						word_bits, want.word_bits));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
				if (line_bits !== want.line_bits)
					report_mismatch($sformatf("line_bits %0d, expected %0d",
						line_bits, want.line_bits));
			end
		end
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items: extremes, every operation, flush of an empty word
		// and the unused operation.
		queue_item(lnwp_pkg::OP_FLUSH_LINE, '0, '0, '0);
		queue_item(lnwp_pkg::OP_RAW_WORD, '0, '0, 9'h000);
		queue_item(lnwp_pkg::OP_RAW_WORD, '1, '1, 9'h1ff);
		queue_item(lnwp_pkg::OP_RAW_WORD, '0, '0, 9'h100);
		queue_item(lnwp_pkg::OP_PIXEL_PAIR, 12'h000, 12'h000, '0);
		queue_item(lnwp_pkg::OP_PIXEL_PAIR, 12'hfff, 12'hfff, '1);
		queue_item(lnwp_pkg::OP_PIXEL_PAIR, 12'ha5a, 12'h5a5, '0);
		queue_item(OP_UNUSED, '1, '1, '1);
		queue_item(lnwp_pkg::OP_RAW_WORD, '0, '0, 9'h0ff);
		queue_item(lnwp_pkg::OP_PIXEL_PAIR, 12'h123, 12'habc, '0);
		queue_item(lnwp_pkg::OP_FLUSH_LINE, '1, '1, '1);
		queue_item(lnwp_pkg::OP_FLUSH_LINE, '0, '0, '0);
		queue_item(lnwp_pkg::OP_PIXEL_PAIR, 12'hfff, 12'h000, '0);
		queue_item(lnwp_pkg::OP_PIXEL_PAIR, 12'h000, 12'hfff, '1);
		queue_item(lnwp_pkg::OP_RAW_WORD, '0, '0, 9'h0aa);
		queue_item(OP_UNUSED, '0, '0, '0);
		queue_item(lnwp_pkg::OP_RAW_WORD, '0, '0, 9'h155);
		queue_item(lnwp_pkg::OP_FLUSH_LINE, '0, '0, '0);
		wait_items_sent();

		// Random lines under the different idling patterns.
		run_phase(0, 0, 300);
		run_phase(82, 0, 300);
		run_phase(0, 82, 300);
		run_phase(36, 36, 300);

		// The receiver holds off while the sender keeps offering, so the
		// block fills and raises full; then the sender waits for every word.
		@(posedge clk);
		sender_idle_pct = 0;
		sink_stall_pct = 0;
		queue_random_lines(150);
		@(negedge clk);
		hold_req = 1'b1;
		@(negedge clk);
		hold_req = 1'b0;
		wait_items_sent();
		wait_words_back();
		run_phase(0, 0, 150);

		// Drain and allow time for any stray word to show up.
		wait_words_back();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/lnwp_pkg.sv
rtl/core/lnwp_fifo.sv
rtl/core/lnwp_front.sv
rtl/core/lnwp_back.sv
rtl/core/lcd_nine_bit_word_packer_unit.sv
rtl/core/lnwp_checker.sv
test/tb_lcd_nine_bit_word_packer_unit.sv
